// File: hdl/vpp_pkg.sv
// Package for the vertex projection block: payload types, constants, register indexes.
// No dependencies; every other file uses it by scoped names.
package vpp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int SIZE_W    = 13;
    localparam int PROD_W    = 64;
    localparam int QW        = 64;

    typedef enum logic [2:0] {
        REG_POS_X        = 3'd0,
        REG_POS_Y        = 3'd1,
        REG_POS_Z        = 3'd2,
        REG_DEPTH_SCALE  = 3'd3,
        REG_DEPTH_OFFSET = 3'd4,
        REG_XY_SCALE     = 3'd5,
        REG_SCREEN_W     = 3'd6,
        REG_SCREEN_H     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [DW-1:0] vertex_x;
        logic signed [DW-1:0] vertex_y;
        logic signed [DW-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [DW-1:0] screen_x;
        logic signed [DW-1:0] screen_y;
        logic signed [DW-1:0] depth_out;
        logic                 depth_was_zero;
    } result_t;

    typedef struct packed {
        logic signed [DW-1:0]   pos_x;
        logic signed [DW-1:0]   pos_y;
        logic signed [DW-1:0]   pos_z;
        logic signed [DW-1:0]   depth_scale;
        logic signed [DW-1:0]   depth_offset;
        logic signed [DW-1:0]   xy_scale;
        logic [SIZE_W-1:0]      screen_width;
        logic [SIZE_W-1:0]      screen_height;
    } cfg_t;

    localparam logic signed [DW-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] S32_MIN = 32'sh8000_0000;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [DW-1:0] sat_w(input logic signed [PROD_W+1:0] v);
        logic signed [PROD_W+1:0] hi;
        logic signed [PROD_W+1:0] lo;
        hi = (PROD_W+2)'(S32_MAX);
        lo = -(PROD_W+2)'(64'sd2147483648);
        if (v > hi)
            return S32_MAX;
        else if (v < lo)
            return S32_MIN;
        else
            return v[DW-1:0];
    endfunction

endpackage

// File: hdl/vpp_cfg.sv
// Configuration register file of the vertex projection block.
// Depends on vpp_pkg.
module vpp_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [vpp_pkg::DW-1:0]      cfg_data,
    output vpp_pkg::cfg_t               cfg
);

    vpp_pkg::cfg_t cfg_reg;
    vpp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (vpp_pkg::reg_index_t'(cfg_index))
                vpp_pkg::REG_POS_X:        cfg_next.pos_x = cfg_data;
                vpp_pkg::REG_POS_Y:        cfg_next.pos_y = cfg_data;
                vpp_pkg::REG_POS_Z:        cfg_next.pos_z = cfg_data;
                vpp_pkg::REG_DEPTH_SCALE:  cfg_next.depth_scale = cfg_data;
                vpp_pkg::REG_DEPTH_OFFSET: cfg_next.depth_offset = cfg_data;
                vpp_pkg::REG_XY_SCALE:     cfg_next.xy_scale = cfg_data;
                vpp_pkg::REG_SCREEN_W:
                    cfg_next.screen_width = cfg_data[vpp_pkg::SIZE_W-1:0];
                vpp_pkg::REG_SCREEN_H:
                    cfg_next.screen_height = cfg_data[vpp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x         <= '0;
            cfg_reg.pos_y         <= '0;
            cfg_reg.pos_z         <= '0;
            cfg_reg.depth_scale   <= 32'sd65543;
            cfg_reg.depth_offset  <= 32'sd6554;
            cfg_reg.xy_scale      <= 32'sd65536;
            cfg_reg.screen_width  <= 13'd640;
            cfg_reg.screen_height <= 13'd480;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/vpp_div.sv
// Pipelined restoring divider: signed 64 bit dividend by signed 32 bit divisor,
// truncating quotient, one quotient bit per stage. Depends on vpp_pkg.
module vpp_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [vpp_pkg::QW-1:0]  dividend,
    input  logic signed [vpp_pkg::DW-1:0]  divisor,
    input  logic                           bypass,
    output logic                           out_valid,
    output logic signed [vpp_pkg::QW:0]    quotient
);

    localparam int N  = vpp_pkg::QW;
    localparam int DV = vpp_pkg::DW;

    // Per stage: remainder, remaining dividend bits (quotient shifts in), divisor, sign.
    logic [N-1:0]  rem_reg  [N+1];
    logic [N-1:0]  quo_reg  [N+1];
    logic [DV-1:0] dvs_reg  [N+1];
    logic          neg_reg  [N+1];
    logic          vld_reg  [N+1];

    logic [N-1:0]  a_mag;
    logic [DV-1:0] b_mag;

    always_comb
    begin
        a_mag = dividend[N-1] ? (~dividend + 1'b1) : dividend;
        b_mag = divisor[DV-1] ? DV'(~divisor + 1'b1) : DV'(divisor);
        if (bypass)
            b_mag = DV'(1);
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        quo_reg[0] <= a_mag;
        dvs_reg[0] <= b_mag;
        neg_reg[0] <= bypass ? dividend[N-1] : (dividend[N-1] ^ divisor[DV-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [N:0] trial;
        logic       ge;
        assign trial = {rem_reg[s], quo_reg[s][N-1]};
        assign ge    = trial >= {{(N+1-DV){1'b0}}, dvs_reg[s]};
        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= ge ? N'(trial - {{(N+1-DV){1'b0}}, dvs_reg[s]}) : trial[N-1:0];
            quo_reg[s+1] <= {quo_reg[s][N-2:0], ge};
            dvs_reg[s+1] <= dvs_reg[s];
            neg_reg[s+1] <= neg_reg[s];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else
                vld_reg[s+1] <= vld_reg[s];
        end
    end

    logic [N:0] q_ext;
    assign q_ext     = {1'b0, quo_reg[N]};
    assign quotient  = neg_reg[N] ? -$signed(q_ext) : $signed(q_ext);
    assign out_valid = vld_reg[N];

endmodule

// File: hdl/vpp_front.sv
// Front stages: translation, depth multiply and remap, xy scale multiply.
// Depends on vpp_pkg.
module vpp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  vpp_pkg::vertex_t               vtx,
    input  vpp_pkg::cfg_t                  cfg,
    output logic                           out_valid,
    output logic signed [vpp_pkg::QW-1:0]  num_x,
    output logic signed [vpp_pkg::QW-1:0]  num_y,
    output logic signed [vpp_pkg::DW-1:0]  depth,
    output logic                           zero
);

    localparam int DW = vpp_pkg::DW;

    // Stage 1: translation.
    logic signed [DW-1:0] tx_reg, ty_reg, tz_reg;
    logic                 v1_reg;
    // Stage 2: products.
    logic signed [2*DW-1:0] mx_reg, my_reg, mz_reg;
    logic signed [DW-1:0]   tx2_reg, ty2_reg;
    logic                   v2_reg;
    // Stage 3: depth remap.
    logic signed [2*DW-1:0] mx3_reg, my3_reg;
    logic signed [DW-1:0]   tx3_reg, ty3_reg, d3_reg;
    logic                   v3_reg;

    logic signed [DW-1:0]   d_next;
    logic signed [2*DW+1:0] d_wide;

    always_comb
    begin
        d_wide = (2*DW+2)'(mz_reg >>> vpp_pkg::FRAC_BITS)
               - (2*DW+2)'(cfg.depth_offset);
        d_next = vpp_pkg::sat_w(d_wide);
    end

    always_ff @(posedge clk)
    begin
        tx_reg  <= vpp_pkg::sat_w((2*DW+2)'(vtx.vertex_x) + (2*DW+2)'(cfg.pos_x));
        ty_reg  <= vpp_pkg::sat_w((2*DW+2)'(vtx.vertex_y) + (2*DW+2)'(cfg.pos_y));
        tz_reg  <= vpp_pkg::sat_w((2*DW+2)'(vtx.vertex_z) + (2*DW+2)'(cfg.pos_z));
        mx_reg  <= tx_reg * cfg.xy_scale;
        my_reg  <= ty_reg * cfg.xy_scale;
        mz_reg  <= tz_reg * cfg.depth_scale;
        tx2_reg <= tx_reg;
        ty2_reg <= ty_reg;
        mx3_reg <= mx_reg;
        my3_reg <= my_reg;
        tx3_reg <= tx2_reg;
        ty3_reg <= ty2_reg;
        d3_reg  <= d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // When depth is zero the divider runs with divisor one on the plain coordinate.
    assign zero      = (d3_reg == '0);
    assign num_x     = zero ? vpp_pkg::QW'(tx3_reg) : mx3_reg;
    assign num_y     = zero ? vpp_pkg::QW'(ty3_reg) : my3_reg;
    assign depth     = d3_reg;
    assign out_valid = v3_reg;

endmodule

// File: hdl/vpp_view.sv
// Viewport stages: saturate quotient, add one, scale by screen size, divide by four.
// Depends on vpp_pkg.
module vpp_view (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [vpp_pkg::QW:0]   qx,
    input  logic signed [vpp_pkg::QW:0]   qy,
    input  logic signed [vpp_pkg::DW-1:0] depth,
    input  logic                          zero,
    input  vpp_pkg::cfg_t                 cfg,
    output logic                          out_valid,
    output vpp_pkg::result_t              res
);

    localparam int DW = vpp_pkg::DW;
    localparam int PW = DW + 2 + vpp_pkg::SIZE_W + 1;

    logic signed [DW:0]   px_reg, py_reg;
    logic signed [DW-1:0] d1_reg, d2_reg;
    logic                 z1_reg, z2_reg, v1_reg, v2_reg;
    logic signed [PW-1:0] sx_reg, sy_reg;

    logic signed [DW:0] one;
    assign one = (DW+1)'(1) <<< vpp_pkg::FRAC_BITS;

    always_ff @(posedge clk)
    begin
        px_reg <= (DW+1)'(vpp_pkg::sat_w((vpp_pkg::PROD_W+2)'(qx))) + one;
        py_reg <= (DW+1)'(vpp_pkg::sat_w((vpp_pkg::PROD_W+2)'(qy))) + one;
        d1_reg <= depth;
        z1_reg <= zero;
        sx_reg <= PW'(px_reg) * $signed({1'b0, cfg.screen_width});
        sy_reg <= PW'(py_reg) * $signed({1'b0, cfg.screen_height});
        d2_reg <= d1_reg;
        z2_reg <= z1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        res.screen_x       = vpp_pkg::sat_w((vpp_pkg::PROD_W+2)'(sx_reg >>> 2));
        res.screen_y       = vpp_pkg::sat_w((vpp_pkg::PROD_W+2)'(sy_reg >>> 2));
        res.depth_out      = d2_reg;
        res.depth_was_zero = z2_reg;
    end
    assign out_valid = v2_reg;

endmodule

// File: hdl/vertex_perspective_project_top.sv
// Top level of the vertex perspective projection block.
// Depends on vpp_pkg, vpp_cfg, vpp_front, vpp_div and vpp_view.
//
// Usage:
//   An input item (one vertex) is accepted at a rising edge with start high and
//   busy low. Busy is always low here: the block is a straight pipeline and
//   takes a new vertex in every cycle.
//   Each result item appears on result for exactly one cycle with done high.
//   The receiver cannot stall, so nothing is ever held back.
//   From acceptance to done an item passes three front stages for
//   translation, the depth and scale multiplies and the depth remap, 65
//   stages of the bit-per-stage divider, and two viewport stages.
//   Throughput is one item per cycle, set by the fully pipelined divider.
//   Configuration registers are written through cfg_we, cfg_index and
//   cfg_data with no wait; write them only while no item is in flight.
//   Reset clears the pipeline valid bits and loads the register defaults.
//   When the remapped depth is zero, the coordinates pass the divider with a
//   divisor of one and depth_was_zero is set in the result.
module vertex_perspective_project_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  vpp_pkg::vertex_t           vertex,
    output logic                       done,
    output vpp_pkg::result_t           result,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [vpp_pkg::DW-1:0]     cfg_data
);

    vpp_pkg::cfg_t cfg;

    logic                            f_valid;
    logic signed [vpp_pkg::QW-1:0]   num_x, num_y;
    logic signed [vpp_pkg::DW-1:0]   depth;
    logic                            zero;

    logic                            dx_valid, dy_valid;
    logic signed [vpp_pkg::QW:0]     qx, qy;

    // Depth and zero flag ride alongside the divider in a delay line.
    localparam int DL = vpp_pkg::QW + 1;
    logic signed [vpp_pkg::DW-1:0]   d_line_reg [DL];
    logic                            z_line_reg [DL];

    assign busy = 1'b0;

    vpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .vtx       (vertex),
        .cfg       (cfg),
        .out_valid (f_valid),
        .num_x     (num_x),
        .num_y     (num_y),
        .depth     (depth),
        .zero      (zero)
    );

    vpp_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .dividend  (num_x),
        .divisor   (depth),
        .bypass    (zero),
        .out_valid (dx_valid),
        .quotient  (qx)
    );

    vpp_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .dividend  (num_y),
        .divisor   (depth),
        .bypass    (zero),
        .out_valid (dy_valid),
        .quotient  (qy)
    );

    always_ff @(posedge clk)
    begin
        d_line_reg[0] <= depth;
        z_line_reg[0] <= zero;
        for (int i = 1; i < DL; i++)
        begin
            d_line_reg[i] <= d_line_reg[i-1];
            z_line_reg[i] <= z_line_reg[i-1];
        end
    end

    vpp_view u_view (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dx_valid),
        .qx        (qx),
        .qy        (qy),
        .depth     (d_line_reg[DL-1]),
        .zero      (z_line_reg[DL-1]),
        .cfg       (cfg),
        .out_valid (done),
        .res       (result)
    );

    // Both dividers see the same valid stream and must stay in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dx_valid == dy_valid)
        else $error("divider lanes out of step");

    // An accepted item shows up as a result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##70 done)
        else $error("result missing after pipeline latency");

    // A zero depth flag always comes with a zero depth value.
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.depth_was_zero == (result.depth_out == '0)))
        else $error("depth zero flag disagrees with depth");

endmodule

// File: bench/tb.sv
// Self-checking testbench for vertex_perspective_project_top.
// Depends on vpp_pkg and the RTL; it predicts each projected vertex and compares results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 70;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    vpp_pkg::vertex_t     vertex;
    logic                 done;
    vpp_pkg::result_t     result;
    logic                 cfg_we;
    logic [2:0]           cfg_index;
    logic [31:0]          cfg_data;

    vertex_perspective_project_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .vertex(vertex),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // The predictor keeps its own copy of the register file.
    longint cur_pos_x, cur_pos_y, cur_pos_z;
    longint cur_dscale, cur_doff, cur_xyscale;
    longint cur_width, cur_height;

    vpp_pkg::vertex_t pending_vertices[$];
    vpp_pkg::result_t projected_results[$];
    int      mismatch_count;
    bit      stimulus_done;
    // Register writes are requested by the initial block and applied by the driver.
    bit                   write_req;
    vpp_pkg::reg_index_t  write_idx;
    logic [31:0]          write_val;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Floor division by a power of two; >>> on a signed longint is arithmetic.
    function automatic longint floor_div_pow2(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint to_screen(input longint p, input longint size);
        return clamp32(floor_div_pow2((p + (64'sd1 <<< vpp_pkg::FRAC_BITS)) * size, 2));
    endfunction

    function automatic vpp_pkg::result_t project_vertex(input vpp_pkg::vertex_t v);
        vpp_pkg::result_t r;
        longint  tx, ty, tz, d, px, py;
        tx = clamp32(longint'(v.vertex_x) + cur_pos_x);
        ty = clamp32(longint'(v.vertex_y) + cur_pos_y);
        tz = clamp32(longint'(v.vertex_z) + cur_pos_z);
        d = clamp32(floor_div_pow2(tz * cur_dscale, vpp_pkg::FRAC_BITS) - cur_doff);
        px = tx;
        py = ty;
        if (d != 0)
        begin
            // SystemVerilog division truncates toward zero, as the block does.
            px = clamp32((tx * cur_xyscale) / d);
            py = clamp32((ty * cur_xyscale) / d);
        end
        r.screen_x = 32'(to_screen(px, cur_width));
        r.screen_y = 32'(to_screen(py, cur_height));
        r.depth_out = 32'(d);
        r.depth_was_zero = (d == 0);
        return r;
    endfunction

    function automatic void apply_register(input vpp_pkg::reg_index_t idx,
                                           input logic [31:0] val);
        case (idx)
            vpp_pkg::REG_POS_X:        cur_pos_x = longint'(signed'(val));
            vpp_pkg::REG_POS_Y:        cur_pos_y = longint'(signed'(val));
            vpp_pkg::REG_POS_Z:        cur_pos_z = longint'(signed'(val));
            vpp_pkg::REG_DEPTH_SCALE:  cur_dscale = longint'(signed'(val));
            vpp_pkg::REG_DEPTH_OFFSET: cur_doff = longint'(signed'(val));
            vpp_pkg::REG_XY_SCALE:     cur_xyscale = longint'(signed'(val));
            vpp_pkg::REG_SCREEN_W:     cur_width = longint'(val[12:0]);
            vpp_pkg::REG_SCREEN_H:     cur_height = longint'(val[12:0]);
            default:          ;
        endcase
    endfunction

    // Driver: presents queued vertices, with a random gap drawn per item.
    // The prediction is made at acceptance so it sees the current registers.
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            vertex <= '0;
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                projected_results.push_back(project_vertex(vertex));
                void'(pending_vertices.pop_front());
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 1) == 0)
                    gap_left = 0;
            end
            if (write_req)
            begin
                // Only requested while idle, so the pipeline is empty.
                cfg_we <= 1'b1;
                cfg_index <= write_idx;
                cfg_data <= write_val;
                apply_register(write_idx, write_val);
                write_req = 1'b0;
                start <= 1'b0;
            end
            else
            begin
                cfg_we <= 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_vertices.size() > 0)
                begin
                    start <= 1'b1;
                    vertex <= pending_vertices[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done pulse is one result item, checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (projected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result %h", result);
            end
            else
            begin
                vpp_pkg::result_t want;
                want = projected_results.pop_front();
                if (want.screen_x !== result.screen_x || want.screen_y !== result.screen_y ||
                    want.depth_out !== result.depth_out ||
                    want.depth_was_zero !== result.depth_was_zero)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"ERROR: expected x=%0d y=%0d d=%0d z=%0b",
                                  " got x=%0d y=%0d d=%0d z=%0b"},
                                 want.screen_x, want.screen_y, want.depth_out,
                                 want.depth_was_zero, result.screen_x, result.screen_y,
                                 result.depth_out, result.depth_was_zero);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_vertices.size() > 0 || projected_results.size() > 0 || start)
            @(posedge clk);
    endtask

    task automatic write_register(input vpp_pkg::reg_index_t idx, input logic [31:0] val);
        write_idx = idx;
        write_val = val;
        write_req = 1'b1;
        while (write_req)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            3: return 32'($signed($urandom_range(0, 400000)) - 200000);
            default: return $urandom;
        endcase
    endfunction

    // Keeps the depth near the usual camera range so most items divide in range.
    function automatic vpp_pkg::vertex_t pick_vertex();
        vpp_pkg::vertex_t v;
        v.vertex_x = ($urandom_range(0, 4) == 0) ? pick_word()
                     : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        v.vertex_y = ($urandom_range(0, 4) == 0) ? pick_word()
                     : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        v.vertex_z = ($urandom_range(0, 4) == 0) ? pick_word()
                     : 32'($urandom_range(1 << 14, 1 << 22));
        return v;
    endfunction

    task automatic random_phase(input int count);
        repeat (count)
            pending_vertices.push_back(pick_vertex());
        wait_idle();
        repeat (LATENCY + 5)
            @(posedge clk);
    endtask

    initial
    begin
        vpp_pkg::vertex_t v;
        cur_pos_x = 0;
        cur_pos_y = 0;
        cur_pos_z = 0;
        cur_dscale = 65543;
        cur_doff = 6554;
        cur_xyscale = 65536;
        cur_width = 640;
        cur_height = 480;
        mismatch_count = 0;
        stimulus_done = 0;
        write_req = 0;
        write_idx = vpp_pkg::REG_POS_X;
        write_val = '0;
        rst_n = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at reset settings: field extremes and a zero remapped depth.
        // With scale 65543 and offset 6554, z = 6554 gives depth 0 exactly
        // and z = 6553 gives depth -1.
        v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
        pending_vertices.push_back(v);
        v = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        pending_vertices.push_back(v);
        v = '{32'sd65536, -32'sd65536, 32'sd6553};
        pending_vertices.push_back(v);
        v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd6553};
        pending_vertices.push_back(v);
        v = '{32'sd0, 32'sd0, 32'sd0};
        pending_vertices.push_back(v);
        v = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd6554};
        pending_vertices.push_back(v);
        v = '{-32'sd1, -32'sd1, -32'sd1};
        pending_vertices.push_back(v);
        v = '{32'sd131072, 32'sd98304, 32'sd327680};
        pending_vertices.push_back(v);
        random_phase(100);

        // Saturating translation, a zero width, a maximum height and a zero scale make every depth
        // equal to minus the offset; offset 0 then forces the pass-through path.
        write_register(vpp_pkg::REG_POS_X, 32'h7FFF_FFFF);
        write_register(vpp_pkg::REG_POS_Y, 32'h8000_0000);
        write_register(vpp_pkg::REG_POS_Z, 32'h7FFF_FFFF);
        write_register(vpp_pkg::REG_DEPTH_SCALE, 32'h0);
        write_register(vpp_pkg::REG_DEPTH_OFFSET, 32'h0);
        write_register(vpp_pkg::REG_SCREEN_W, 32'h0);
        write_register(vpp_pkg::REG_SCREEN_H, 32'h1FFF);
        v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5};
        pending_vertices.push_back(v);
        v = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        pending_vertices.push_back(v);
        random_phase(60);

        // Extreme scales and offsets with a 4096 wide, 1 high screen.
        write_register(vpp_pkg::REG_POS_X, 32'h8000_0000);
        write_register(vpp_pkg::REG_POS_Y, 32'h7FFF_FFFF);
        write_register(vpp_pkg::REG_POS_Z, 32'h8000_0000);
        write_register(vpp_pkg::REG_DEPTH_SCALE, 32'h7FFF_FFFF);
        write_register(vpp_pkg::REG_DEPTH_OFFSET, 32'h8000_0000);
        write_register(vpp_pkg::REG_XY_SCALE, 32'h8000_0000);
        write_register(vpp_pkg::REG_SCREEN_W, 32'd4096);
        write_register(vpp_pkg::REG_SCREEN_H, 32'd1);
        random_phase(60);

        write_register(vpp_pkg::REG_DEPTH_SCALE, 32'h8000_0000);
        write_register(vpp_pkg::REG_DEPTH_OFFSET, 32'h7FFF_FFFF);
        write_register(vpp_pkg::REG_XY_SCALE, 32'h7FFF_FFFF);
        random_phase(60);

        // Random settings, mostly camera-like, for the bulk of the items.
        repeat (10)
        begin
            write_register(vpp_pkg::REG_POS_X, ($urandom_range(0, 3) == 0) ? pick_word()
                           : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
            write_register(vpp_pkg::REG_POS_Y, ($urandom_range(0, 3) == 0) ? pick_word()
                           : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
            write_register(vpp_pkg::REG_POS_Z, ($urandom_range(0, 3) == 0) ? pick_word()
                           : 32'($urandom_range(0, 1 << 18)));
            write_register(vpp_pkg::REG_DEPTH_SCALE, ($urandom_range(0, 3) == 0)
                           ? pick_word() : 32'($urandom_range(65536, 70000)));
            write_register(vpp_pkg::REG_DEPTH_OFFSET, ($urandom_range(0, 3) == 0)
                           ? pick_word() : 32'($urandom_range(0, 20000)));
            write_register(vpp_pkg::REG_XY_SCALE, ($urandom_range(0, 3) == 0)
                           ? pick_word() : 32'($urandom_range(30000, 200000)));
            write_register(vpp_pkg::REG_SCREEN_W, $urandom);
            write_register(vpp_pkg::REG_SCREEN_H, 32'($urandom_range(1, 4096)));
            random_phase(107);
        end
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done);
        repeat (LATENCY + 10)
            @(posedge clk);
        if (mismatch_count == 0 && projected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // About 1400 items with their random gaps plus phase drains stay far below this.
    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// File: sim.f
hdl/vpp_pkg.sv
hdl/vpp_cfg.sv
hdl/vpp_div.sv
hdl/vpp_front.sv
hdl/vpp_view.sv
hdl/vertex_perspective_project_top.sv
bench/tb.sv
